### hdl/stbs_pkg.sv
// Shared types and constants for the sorted table binary search core.
// Holds the word formats, mode codes and table sizing; no dependencies.
package stbs_pkg;

    // Table sizing.
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int IDX_W       = 10;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // Input word mode codes.
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    // Input word: one command.
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] key;
    } t_in_word;

    // Output word: one query answer.
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] found_index;
    } t_out_word;

    // Command handed to the search engine.
    typedef struct packed {
        logic     valid;
        t_in_word word;
    } t_req;

    // Answer leaving the search engine.
    typedef struct packed {
        logic      valid;
        t_out_word word;
    } t_res;

    // Engine status seen by the top level.
    typedef struct packed {
        logic             idle;
        logic [CNT_W-1:0] count;
    } t_status;

endpackage

### hdl/stbs_search.sv
// Key table memory, entry count and the binary search sequencer.
// Depends on stbs_pkg for types, mode codes and table sizing.
module stbs_search (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stbs_pkg::t_req    i_req,
    input  logic              i_res_ready,
    output stbs_pkg::t_res    o_res,
    output stbs_pkg::t_status o_status
);
    import stbs_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    logic [31:0]        mem [TABLE_DEPTH];

    logic [1:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_lo, n_lo;
    logic [CNT_W-1:0]   r_end, n_end;
    logic [ADDR_W-1:0]  r_mid, n_mid;
    logic signed [31:0] r_key, n_key;
    logic signed [31:0] r_rd_data;

    logic               w_rd_en;
    logic               w_wr_en;
    logic               w_eq;
    logic               w_gt;
    logic [CNT_W-1:0]   w_cand_lo;
    logic [CNT_W-1:0]   w_cand_end;
    logic [CNT_W:0]     w_sum;
    logic [ADDR_W-1:0]  w_mid;
    logic               w_more;

    // Compare the probed entry with the query key.
    assign w_eq = (r_rd_data == r_key);
    assign w_gt = (r_rd_data > r_key);

    // Candidate bounds: seeded from the count when idle, narrowed after a probe.
    // The upper bound is exclusive, so the window is lo .. end-1.
    always_comb begin
        if (r_state == ST_IDLE) begin
            w_cand_lo  = '0;
            w_cand_end = r_count;
        end else if (w_gt) begin
            w_cand_lo  = r_lo;
            w_cand_end = CNT_W'(r_mid);
        end else begin
            w_cand_lo  = CNT_W'(r_mid) + CNT_W'(1);
            w_cand_end = r_end;
        end
    end

    // Next probe point is the floor of the midpoint of the window.
    assign w_sum  = {1'b0, w_cand_lo} + {1'b0, w_cand_end} - (CNT_W + 1)'(1);
    assign w_mid  = w_sum[ADDR_W:1];
    assign w_more = (w_cand_lo < w_cand_end);

    // Sequencer: one memory probe per cycle while a query runs, as long as the output side is ready (i_res_ready).
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_lo    = r_lo;
        n_end   = r_end;
        n_mid   = r_mid;
        n_key   = r_key;
        w_rd_en = 1'b0;
        w_wr_en = 1'b0;
        o_res   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    case (i_req.word.mode)
                        MODE_CLEAR: begin
                            n_count = '0;
                        end
                        MODE_APPEND: begin
                            if (r_count < DEPTH_CNT) begin
                                w_wr_en = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        MODE_QUERY: begin
                            n_key = i_req.word.key;
                            if (w_more) begin
                                w_rd_en = 1'b1;
                                n_lo    = w_cand_lo;
                                n_end   = w_cand_end;
                                n_mid   = w_mid;
                                n_state = ST_PROBE;
                            end else begin
                                n_state = ST_EMPTY;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PROBE: begin
                if (i_res_ready) begin
                    if (w_eq) begin
                        o_res.valid                  = 1'b1;
                        o_res.word.found             = 1'b1;
                        o_res.word.found_index       = IDX_W'(r_mid);
                        n_state                      = ST_IDLE;
                    end else if (w_more) begin
                        w_rd_en = 1'b1;
                        n_lo    = w_cand_lo;
                        n_end   = w_cand_end;
                        n_mid   = w_mid;
                    end else begin
                        o_res.valid = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end
            end
            ST_EMPTY: begin
                if (i_res_ready) begin
                    o_res.valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Key table: append port writes at the fill point, probe port reads at mid.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[r_count[ADDR_W-1:0]] <= i_req.word.key;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[w_mid];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Search bounds and key.
    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_end <= n_end;
        r_mid <= n_mid;
        r_key <= n_key;
    end

    assign o_status.idle  = (r_state == ST_IDLE);
    assign o_status.count = r_count;

endmodule

### hdl/sorted_table_binary_search_core.sv
// Top level of the sorted table binary search core: handshakes and output register.
// Depends on stbs_pkg and stbs_search.
//
// A table of up to 1024 signed 32-bit keys is loaded in ascending order with
// append words and emptied with a clear word; both give no answer, and an
// append to a full table is dropped. A query word runs a binary search and
// gives one answer word: found and the index of the matching entry (0 on a
// miss). The table sits in one single-port-read memory with a registered read,
// and the search probes one entry per cycle while the output register is free.
// While the output register is full and held, every probe step waits, so a
// held answer stretches the next query by the length of the hold. One word is
// worked on at a time; the next word is taken once the answer is in the output
// register, even while that answer still waits to be taken.
module sorted_table_binary_search_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  stbs_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output stbs_pkg::t_out_word o_out_word
);
    import stbs_pkg::*;

    t_req      w_req;
    t_res      w_res;
    t_status   w_status;
    logic      w_res_ready;
    logic      r_out_valid;
    t_out_word r_out_word;

    // Input side: words enter only while the engine is idle.
    assign o_in_stall  = !w_status.idle;
    assign w_req.valid = i_in_valid && !o_in_stall;
    assign w_req.word  = i_in_word;

    // Output slot is free when empty or being taken this cycle.
    assign w_res_ready = !r_out_valid || !i_out_stall;

    stbs_search u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_status    (w_status)
    );

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_res.valid) begin
            r_out_word <= w_res.word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // The engine never finishes into an occupied, stalled output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> !(r_out_valid && i_out_stall))
        else $error("answer produced while output register is held");

    // A miss always reports index zero.
    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_word.found) |-> (r_out_word.found_index == '0))
        else $error("miss with nonzero index");

    // The fill count never passes the table depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.count <= DEPTH_CNT)
        else $error("entry count beyond table depth");

    // An accepted query always takes the engine out of its idle state.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req.valid && (i_in_word.mode == MODE_QUERY)) |=> !w_status.idle)
        else $error("query accepted but engine stayed idle");

endmodule

### sim/tb_top.sv
// Self-checking testbench for the sorted table binary search core.
// Depends on stbs_pkg and sorted_table_binary_search_core; drives random and
// directed command words and checks every answer word against its own search.
`timescale 1ns / 100ps

module tb_top;
    import stbs_pkg::*;

    // Mode code that the core must ignore.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

    localparam int RANDOM_WORDS   = 526;
    localparam int IDLE_PCT       = 36;
    localparam int QUIET_FROM     = 300;
    localparam int QUIET_TO       = 440;
    localparam int HOLD_AT        = 90;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 30;
    localparam int MAX_REPORTS    = 10;

    logic      i_clk   = 1'b0;
    logic      rst_n   = 1'b0;
    logic      in_valid = 1'b0;
    logic      o_in_stall;
    t_in_word  in_word = '0;
    logic      o_out_valid;
    logic      out_stall = 1'b0;
    t_out_word o_out_word;

    // Command words waiting for the driver and answers still owed by the core.
    t_in_word  words_to_send[$];
    t_out_word answers_due[$];

    // Our own copy of the table, updated as command words are accepted.
    logic signed [31:0] key_store [TABLE_DEPTH];
    int                 stored_count = 0;

    // Keys known to be loaded, used only to aim queries at hits.
    int loaded_keys[$];

    int words_pushed   = 0;
    int counted_words  = 0;
    int in_accepted    = 0;
    int answers_seen   = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;
    int hold_left      = 0;
    logic hold_done    = 1'b0;

    int n_query   = 0;
    int n_append  = 0;
    int n_dropped = 0;
    int n_clear   = 0;
    int n_ignored = 0;
    int max_fill  = 0;

    sorted_table_binary_search_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_word (o_out_word)
    );

    always #2 i_clk = ~i_clk;

    // Binary search over the loaded entries, stopping at the first probe that hits.
    function automatic t_out_word search_table(logic signed [31:0] key);
        int        lo;
        int        hi;
        int        mid;
        t_out_word ans;
        ans = '0;
        lo  = 0;
        hi  = stored_count - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (key_store[mid] == key) begin
                ans.found       = 1'b1;
                ans.found_index = IDX_W'(mid);
                return ans;
            end else if (key_store[mid] > key) begin
                hi = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        return ans;
    endfunction

    // Apply one accepted command word to our copy of the table.
    task automatic track_word(t_in_word w);
        case (w.mode)
            MODE_CLEAR: begin
                stored_count = 0;
                n_clear++;
            end
            MODE_APPEND: begin
                n_append++;
                if (stored_count < TABLE_DEPTH) begin
                    key_store[stored_count] = w.key;
                    stored_count++;
                    if (stored_count > max_fill) max_fill = stored_count;
                end else begin
                    n_dropped++;
                end
            end
            MODE_QUERY: begin
                n_query++;
                answers_due = {answers_due, search_table(w.key)};
            end
            default: n_ignored++;
        endcase
    endtask

    // Queue one command word for the driver.
    task automatic send(logic [1:0] mode, logic signed [31:0] key);
        t_in_word w;
        w.mode = mode;
        w.key  = key;
        words_to_send = {words_to_send, w};
        words_pushed++;
        if (mode != MODE_UNUSED) counted_words++;
        if (mode == MODE_CLEAR) loaded_keys.delete();
        if (mode == MODE_APPEND && loaded_keys.size() < TABLE_DEPTH)
            loaded_keys = {loaded_keys, int'(key)};
    endtask

    // Append n keys in ascending order, with random spacing and some duplicates.
    task automatic load_ascending(int n);
        longint cur;
        longint step_max;
        cur = -64'sd2147483648 + longint'({32'd0, $urandom()}) / $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            step_max = (64'sd2147483647 - cur) / (n - i);
            step_max = step_max >>> $urandom_range(0, 24);
            if (i > 0) cur += longint'({32'd0, $urandom()}) % (step_max + 1);
            send(MODE_APPEND, cur[31:0]);
        end
    endtask

    // Pick a query key: mostly a loaded key, sometimes a neighbor, sometimes anything.
    function automatic logic signed [31:0] pick_query_key();
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (loaded_keys.size() == 0 || r >= 80) return $urandom();
        k = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
        if (r < 55) return k;
        return $urandom_range(0, 1) ? k + 1 : k - 1;
    endfunction

    // Wait until every queued word was taken and every answer has come back.
    task automatic wait_drained();
        while (in_accepted != words_pushed || answers_due.size() != 0) @(negedge i_clk);
    endtask

    // Sender: offers the next queued word, idling at random outside the quiet window.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                track_word(in_word);
                in_accepted <= in_accepted + 1;
            end
            if (!in_valid || !o_in_stall) begin
                if (words_to_send.size() > 0 &&
                    !((in_accepted < QUIET_FROM || in_accepted >= QUIET_TO) &&
                      $urandom_range(0, 99) < IDLE_PCT)) begin
                    in_word  <= words_to_send.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each answer word and drives stall, with one long hold-off.
    always @(posedge i_clk) begin : answer_check
        t_out_word want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                answers_seen++;
                if (answers_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("MISMATCH: answer with none owed, got found=%0d index=%0d",
                                 o_out_word.found, o_out_word.found_index);
                end else begin
                    want = answers_due.pop_front();
                    if (o_out_word.found !== want.found ||
                        o_out_word.found_index !== want.found_index) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"MISMATCH: expected found=%0d index=%0d, ",
                                      "got found=%0d index=%0d"},
                                     want.found, want.found_index,
                                     o_out_word.found, o_out_word.found_index);
                    end
                end
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (!hold_done && in_accepted >= HOLD_AT) begin
                out_stall <= 1'b1;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end else if (in_accepted >= QUIET_FROM && in_accepted < QUIET_TO) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Watchdog: ends the run if no word moves on either side for too long.
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles", quiet_cycles);
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus and end of run.
    initial begin : stimulus
        int start_count;
        int r;
        int n;
        int left;
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;

        // Directed words: empty table, extremes, duplicates, ignored mode, unsorted table.
        send(MODE_QUERY, 32'sd0);
        send(MODE_UNUSED, 32'sd5);
        send(MODE_APPEND, KEY_MIN);
        send(MODE_APPEND, -32'sd1);
        send(MODE_APPEND, 32'sd0);
        send(MODE_APPEND, 32'sd0);
        send(MODE_APPEND, 32'sd5);
        send(MODE_APPEND, KEY_MAX);
        send(MODE_QUERY, KEY_MIN);
        send(MODE_QUERY, KEY_MAX);
        send(MODE_QUERY, -32'sd1);
        send(MODE_QUERY, 32'sd0);
        send(MODE_QUERY, 32'sd5);
        send(MODE_QUERY, 32'sd3);
        send(MODE_QUERY, -32'sd2);
        send(MODE_CLEAR, 32'sd0);
        send(MODE_QUERY, 32'sd5);
        send(MODE_APPEND, 32'sd9);
        send(MODE_APPEND, 32'sd1);
        send(MODE_APPEND, 32'sd7);
        send(MODE_QUERY, 32'sd1);
        send(MODE_QUERY, 32'sd9);
        send(MODE_QUERY, 32'sd7);
        send(MODE_CLEAR, KEY_MAX);

        // The stimulus waits here until the core has taken and answered everything.
        wait_drained();

        // Random part: mostly clean load-and-search sequences, some noise.
        start_count = counted_words;
        while (counted_words - start_count < RANDOM_WORDS) begin
            r = $urandom_range(0, 99);
            if (r < 82) begin
                send(MODE_CLEAR, $urandom());
                r = $urandom_range(0, 99);
                if (r < 80)      n = $urandom_range(0, 24);
                else if (r < 95) n = $urandom_range(25, 120);
                else             n = $urandom_range(121, 300);
                // Keep the last load from running far past the word budget.
                left = RANDOM_WORDS - (counted_words - start_count);
                if (n > left) n = (left > 0) ? left : 0;
                load_ascending(n);
                repeat ($urandom_range(1, 12)) send(MODE_QUERY, pick_query_key());
            end else if (r < 92) begin
                repeat ($urandom_range(1, 6)) send(2'($urandom_range(0, 3)), $urandom());
            end else begin
                // Unsorted tail appended onto whatever is loaded.
                repeat ($urandom_range(1, 5)) send(MODE_APPEND, $urandom());
                repeat ($urandom_range(1, 6)) send(MODE_QUERY, pick_query_key());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Run covered %0d queries, %0d appends (%0d dropped when full),",
                 n_query, n_append, n_dropped);
        $display("%0d clears, %0d ignored words; checked %0d answers, table held up to %0d keys.",
                 n_clear, n_ignored, answers_seen, max_fill);
        if (mismatches == 0 && answers_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
